// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// When ante holds, cons must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante implies cons");
// expr must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`endif

`endif

// ----- rtl/core/iconv_pkg.sv -----
// Shared constants and types for the integer to ASCII converter.
package iconv_pkg;

   localparam int WORD_BITS   = 32;
   localparam int MAX_PAD     = 16;
   localparam int BUF_DEPTH   = WORD_BITS + 1;
   localparam int ADDR_BITS   = $clog2(BUF_DEPTH);
   localparam int COUNT_BITS  = $clog2(BUF_DEPTH + 1);
   localparam int LEN_BITS    = $clog2(MAX_PAD + 1);

   // radix magnitude reaches 64, so a remainder fits in 6 bits
   localparam int BASE_BITS   = 7;
   localparam int REM_BITS    = 6;
   localparam int CHAR_BITS   = 7;
   localparam int RADIX_BITS  = 7;
   localparam int WIDTH_BITS  = 6;

   // divider retires this many quotient bits per cycle
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = WORD_BITS / DIV_BITS_PER_CYCLE;
   localparam int DIV_STEP_BITS      = $clog2(DIV_CYCLES);

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] LETTER_GAP = 7'd7;
   localparam logic [REM_BITS-1:0]  DEC_LIMIT  = 6'd10;
   localparam logic [BASE_BITS-1:0] MIN_BASE   = 7'd2;

   // divider status seen by the sequencer
   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] quotient;
      logic [REM_BITS-1:0]  remainder;
   } div_stat_type;

endpackage

// ----- rtl/core/iconv_ram.sv -----
// Generic single-port-write, registered-read RAM.
module iconv_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/iconv_div.sv -----
// Iterative radix divider: WORD_BITS dividend by a small divisor, 4 bits a cycle.
module iconv_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [iconv_pkg::WORD_BITS-1:0]    dividend,
   input  logic [iconv_pkg::BASE_BITS-1:0]    divisor,
   output iconv_pkg::div_stat_type            stat
);

   logic                                  busy_ff,    busy_in;
   logic                                  done_ff,    done_in;
   logic [iconv_pkg::DIV_STEP_BITS-1:0]   step_ff,    step_in;
   logic [iconv_pkg::WORD_BITS-1:0]       work_ff,    work_in;
   logic [iconv_pkg::REM_BITS-1:0]        rem_ff,     rem_in;
   logic [iconv_pkg::BASE_BITS-1:0]       divisor_ff, divisor_in;

   logic [iconv_pkg::WORD_BITS-1:0]       work_nx;
   logic [iconv_pkg::REM_BITS-1:0]        rem_nx;

   // restoring division steps for one cycle; remainder stays below the divisor
   always_comb begin
      logic [iconv_pkg::BASE_BITS-1:0] trial;
      work_nx = work_ff;
      rem_nx  = rem_ff;
      for (int i = 0; i < iconv_pkg::DIV_BITS_PER_CYCLE; i++) begin
         trial   = {rem_nx, work_nx[iconv_pkg::WORD_BITS-1]};
         work_nx = {work_nx[iconv_pkg::WORD_BITS-2:0], 1'b0};
         if (trial >= divisor_ff) begin
            rem_nx     = iconv_pkg::REM_BITS'(trial - divisor_ff);
            work_nx[0] = 1'b1;
         end else begin
            rem_nx = trial[iconv_pkg::REM_BITS-1:0];
         end
      end
   end

   // step control
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         work_in = work_nx;
         rem_in  = rem_nx;
         step_in = step_ff + 1'b1;
         if (step_ff == iconv_pkg::DIV_STEP_BITS'(iconv_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         work_ff <= '0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
   end

   assign stat = '{done: done_ff, quotient: work_ff, remainder: rem_ff};

endmodule

// ----- rtl/core/integer_to_ascii_converter_unit.sv -----
// Top level of the integer to ASCII converter: sequencer, divider and character buffer.
//
// Usage:
//   req channel: one beat per number. req_tdata carries value_bits, radix and
//   pad_width. A negative radix selects signed conversion, a negative width
//   selects '0' padding (padding goes ahead of the sign), width capped at 16.
//   rsp channel: one beat per character, most significant first, rsp_tlast on
//   the final character of the number.
// Timing:
//   req_tready is high only while no number is being converted. Each digit
//   passes through the shared divider (steps of 4 quotient bits, then the
//   buffer write); the buffer is built from D digits, then the sign in its
//   own state, then P pad characters, and each character is read back through
//   the buffer read, the output register and the next read address.
//   The last character sits in the output register while the next number is
//   accepted and divided; a stalled receiver holds the beat and stops readout.
// Reset: synchronous; clears the sequencer, divider control and rsp_tvalid.
`include "assert_macros.svh"

module integer_to_ascii_converter_unit (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] value_bits, [38:32] radix, [44:39] pad_width
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] character
   output logic        rsp_tlast
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV  = 7'b0000010,
      S_SIGN = 7'b0000100,
      S_PAD  = 7'b0001000,
      S_RD   = 7'b0010000,
      S_LOAD = 7'b0100000,
      S_HOLD = 7'b1000000
   } state_type;

   state_type                               state_ff,   state_in;
   logic [iconv_pkg::COUNT_BITS-1:0]        count_ff,   count_in;
   logic [iconv_pkg::ADDR_BITS-1:0]         rd_idx_ff,  rd_idx_in;
   logic [iconv_pkg::BASE_BITS-1:0]         base_ff,    base_in;
   logic                                    neg_ff,     neg_in;
   logic [iconv_pkg::LEN_BITS-1:0]          len_ff,     len_in;
   logic [iconv_pkg::CHAR_BITS-1:0]         pad_ff,     pad_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [iconv_pkg::CHAR_BITS-1:0]         rsp_char_ff,  rsp_char_in;
   logic                                    rsp_last_ff,  rsp_last_in;

   // request fields
   logic [iconv_pkg::WORD_BITS-1:0]         value_bits;
   logic [iconv_pkg::RADIX_BITS-1:0]        radix;
   logic [iconv_pkg::WIDTH_BITS-1:0]        pad_width;

   logic                                    req_accept;
   logic                                    rsp_accept;
   logic [iconv_pkg::BASE_BITS-1:0]         radix_mag;
   logic [iconv_pkg::BASE_BITS-1:0]         base_new;
   logic                                    neg_new;
   logic [iconv_pkg::WORD_BITS-1:0]         value_new;
   logic [iconv_pkg::WIDTH_BITS-1:0]        width_mag;
   logic [iconv_pkg::LEN_BITS-1:0]          len_new;

   logic                                    div_start;
   logic [iconv_pkg::WORD_BITS-1:0]         div_dividend;
   iconv_pkg::div_stat_type                 div_stat;
   logic [iconv_pkg::CHAR_BITS-1:0]         digit_char;

   logic                                    wr_en;
   logic [iconv_pkg::CHAR_BITS-1:0]         wr_data;
   logic [iconv_pkg::CHAR_BITS-1:0]         rd_data;

   assign value_bits = req_tdata[31:0];
   assign radix      = req_tdata[38:32];
   assign pad_width  = req_tdata[44:39];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;

   // decode a new request: base, sign handling, pad length
   always_comb begin
      radix_mag = radix[iconv_pkg::RADIX_BITS-1] ? (iconv_pkg::BASE_BITS'(0) - radix) : radix;
      base_new  = (radix_mag < iconv_pkg::MIN_BASE) ? iconv_pkg::MIN_BASE : radix_mag;
      neg_new   = radix[iconv_pkg::RADIX_BITS-1] && value_bits[iconv_pkg::WORD_BITS-1];
      value_new = neg_new ? (iconv_pkg::WORD_BITS'(0) - value_bits) : value_bits;
      width_mag = pad_width[iconv_pkg::WIDTH_BITS-1]
                  ? (iconv_pkg::WIDTH_BITS'(0) - pad_width) : pad_width;
      if (width_mag > iconv_pkg::WIDTH_BITS'(iconv_pkg::MAX_PAD)) begin
         len_new = iconv_pkg::LEN_BITS'(iconv_pkg::MAX_PAD);
      end else begin
         len_new = width_mag[iconv_pkg::LEN_BITS-1:0];
      end
   end

   // digit to ASCII: letters continue past '9' with a gap
   always_comb begin
      digit_char = iconv_pkg::CHAR_BITS'(div_stat.remainder) + iconv_pkg::CHAR_ZERO;
      if (div_stat.remainder >= iconv_pkg::DEC_LIMIT) begin
         digit_char = digit_char + iconv_pkg::LETTER_GAP;
      end
   end

   // shared divider
   assign div_start    = req_accept ||
                         ((state_ff == S_DIV) && div_stat.done && (div_stat.quotient != '0));
   assign div_dividend = req_accept ? value_new : div_stat.quotient;

   iconv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (req_accept ? base_new : base_ff),
      .stat     (div_stat)
   );

   // character buffer, filled least significant first
   iconv_ram #(
      .WIDTH (iconv_pkg::CHAR_BITS),
      .DEPTH (iconv_pkg::BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[iconv_pkg::ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      len_in       = len_ff;
      pad_in       = pad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_data      = digit_char;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               base_in  = base_new;
               neg_in   = neg_new;
               len_in   = len_new;
               pad_in   = pad_width[iconv_pkg::WIDTH_BITS-1]
                          ? iconv_pkg::CHAR_ZERO : iconv_pkg::CHAR_SPACE;
               count_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (div_stat.quotient == '0) begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            if (neg_ff) begin
               wr_en    = 1'b1;
               wr_data  = iconv_pkg::CHAR_MINUS;
               count_in = count_ff + 1'b1;
            end
            state_in = S_PAD;
         end
         S_PAD: begin
            if (count_ff < iconv_pkg::COUNT_BITS'(len_ff)) begin
               wr_en    = 1'b1;
               wr_data  = pad_ff;
               count_in = count_ff + 1'b1;
            end else begin
               rd_idx_in = iconv_pkg::ADDR_BITS'(count_ff - 1'b1);
               state_in  = S_RD;
            end
         end
         S_RD: begin
            // wait until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = rd_data;
            rsp_last_in  = (rd_idx_ff == '0);
            if (rd_idx_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff - 1'b1;
               state_in  = S_HOLD;
            end
         end
         S_HOLD: begin
            // lets the new read address pass through the registered buffer read
            state_in = S_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      len_ff      <= len_in;
      pad_ff      <= pad_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_ALWAYS(a_count_in_range, clock, reset,
      count_ff <= iconv_pkg::COUNT_BITS'(iconv_pkg::BUF_DEPTH))
   `ASSERT_IMPL(a_done_only_in_div, clock, reset, div_stat.done, state_ff == S_DIV)
   `ASSERT_IMPL(a_load_into_free_reg, clock, reset, state_ff == S_LOAD, !rsp_valid_ff)

endmodule

// ----- bench/integer_to_ascii_converter_unit_test.sv -----
// Self-checking bench for the integer to ASCII converter: directed table, then random numbers.
`timescale 1ns / 100ps

module integer_to_ascii_converter_unit_test;

   localparam int NUMBER_COUNT   = 400;
   localparam int MAX_IDLE       = 17;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 400;
   localparam int REPORT_LIMIT   = 10;
   localparam int HOLD_AT_NUMBER = 100;
   localparam int DRAIN_AT_NUMBER = 200;
   localparam int QUIET_FIRST    = 250;
   localparam int QUIET_LAST     = 299;

   // one character beat as the receiver should see it
   typedef struct {
      logic [iconv_pkg::CHAR_BITS-1:0] code;
      logic                            last;
   } ascii_beat_type;

   // one directed number; an empty text means the predictor supplies the characters
   typedef struct {
      logic [iconv_pkg::WORD_BITS-1:0]         value;
      logic signed [iconv_pkg::RADIX_BITS-1:0] radix;
      logic signed [iconv_pkg::WIDTH_BITS-1:0] width;
      string                                   text;
   } number_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [31:0] value_bits, [38:32] radix, [44:39] pad_width
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [6:0] character
   logic        rsp_tlast;

   ascii_beat_type pending_chars[$];
   int unsigned fault_count = 0;
   bit          send_quiet  = 0;
   bit          rsp_quiet   = 0;
   bit          hold_rsp    = 0;

   number_row_type directed_rows [25] = '{
      '{32'h0000_0000,  10,   0, "0"},
      '{32'hFFFF_FFFF,  16,   0, "FFFFFFFF"},
      '{32'hFFFF_FFFF,  10,   0, "4294967295"},
      '{32'hFFFF_FFFF, -10,   0, "-1"},
      '{32'h8000_0000, -10,   0, "-2147483648"},
      '{32'h8000_0000, -16,   0, "-80000000"},
      '{32'h7FFF_FFFF, -10,   0, "2147483647"},
      '{32'hFFFF_FFFF,   2,   0, ""},
      '{32'h8000_0000,  -2, -16, ""},
      '{32'h0000_0005,   0,   0, "101"},
      '{32'h0000_0005,   1,   0, "101"},
      '{32'h0000_0005,  -1,   0, "101"},
      '{32'hFFFF_FFFB, -10,  -3, "0-5"},
      '{32'hFFFF_FFFB, -10,   3, " -5"},
      '{32'h0000_0007,  10,  31, ""},
      '{32'h0000_0007,  10, -32, ""},
      '{32'h0000_0023,  36,   0, "Z"},
      '{32'h0000_0024,  37,   0, "["},
      '{32'h0000_003F, -64,   0, "v"},
      '{32'hFFFF_FFFF, -64,   0, "-1"},
      '{32'h0000_003E,  63,   0, "u"},
      '{32'h0000_00FF,   8,  16, ""},
      '{32'h0000_0000, -10,  -1, "0"},
      '{32'h1234_ABCD,  36, -12, ""},
      '{32'h0000_0000, -36,  31, ""}
   };

   integer_to_ascii_converter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the characters of one number and queue them, most significant first.
   function automatic void predict_chars(
      input logic [iconv_pkg::WORD_BITS-1:0]         value,
      input logic signed [iconv_pkg::RADIX_BITS-1:0] radix,
      input logic signed [iconv_pkg::WIDTH_BITS-1:0] width);
      logic [iconv_pkg::WORD_BITS-1:0] remaining;
      logic [iconv_pkg::CHAR_BITS-1:0] pad_char;
      logic [iconv_pkg::CHAR_BITS-1:0] text[$];
      int unsigned                     base;
      int unsigned                     field;
      int unsigned                     digit;
      logic                            negative;
      remaining = value;
      negative  = 1'b0;
      pad_char  = iconv_pkg::CHAR_SPACE;
      // negative radix: signed conversion; the most negative word wraps onto itself
      if (radix < 0) begin
         base = -int'(radix);
         if (value[iconv_pkg::WORD_BITS-1]) begin
            remaining = -value;
            negative  = 1'b1;
         end
      end else begin
         base = int'(radix);
      end
      if (base < 2) base = 2;
      if (width < 0) begin
         field    = -int'(width);
         pad_char = iconv_pkg::CHAR_ZERO;
      end else begin
         field = int'(width);
      end
      if (field > iconv_pkg::MAX_PAD) field = iconv_pkg::MAX_PAD;
      // digits land least significant first; letters continue past 'Z' for big bases
      do begin
         digit = remaining % base;
         if (digit >= iconv_pkg::DEC_LIMIT) digit += iconv_pkg::LETTER_GAP;
         text.push_front(iconv_pkg::CHAR_BITS'(digit + iconv_pkg::CHAR_ZERO));
         remaining = remaining / base;
      end while (remaining != 0);
      if (negative) text.push_front(iconv_pkg::CHAR_MINUS);
      // pad sits ahead of the sign; 33 characters at most, so depth never limits it
      while (text.size() < field) text.push_front(pad_char);
      foreach (text[i]) pending_chars.push_back('{text[i], i == text.size() - 1});
   endfunction

   function automatic void report_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%s", what);
   endfunction

   // Offer one number after a random gap; queue its characters once the beat is taken.
   task automatic send_number(input logic [iconv_pkg::WORD_BITS-1:0]         value,
                              input logic signed [iconv_pkg::RADIX_BITS-1:0] radix,
                              input logic signed [iconv_pkg::WIDTH_BITS-1:0] width,
                              input string text);
      int unsigned gap;
      gap = send_quiet ? 0 : $urandom_range(MAX_IDLE, 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {3'b000, width, radix, value};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (text.len() == 0) begin
         predict_chars(value, radix, width);
      end else begin
         for (int i = 0; i < text.len(); i++)
            pending_chars.push_back('{iconv_pkg::CHAR_BITS'(text[i]), i == text.len() - 1});
      end
      @(negedge clock);
   endtask

   // stimulus: reset, directed table, random numbers, drain
   initial begin : stimulus
      logic [iconv_pkg::WORD_BITS-1:0]         value;
      logic signed [iconv_pkg::RADIX_BITS-1:0] radix;
      logic signed [iconv_pkg::WIDTH_BITS-1:0] width;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_number(directed_rows[i].value, directed_rows[i].radix,
                     directed_rows[i].width, directed_rows[i].text);

      for (int n = 0; n < NUMBER_COUNT; n++) begin
         // receiver holds off for a long stretch while numbers keep coming
         if (n == HOLD_AT_NUMBER) hold_rsp = 1'b1;
         // sender waits until every character is out
         if (n == DRAIN_AT_NUMBER) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (pending_chars.size() != 0);
         end
         send_quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
         rsp_quiet  = send_quiet;
         case ($urandom_range(3, 0))
            0:       value = $urandom;
            1:       value = $urandom_range(1000, 0);
            2:       value = -$urandom_range(1000, 0);
            default: value = {1'b1, 27'd0, 4'($urandom_range(15, 0))}
                             ^ {1'($urandom_range(1, 0)), 31'd0};
         endcase
         if ($urandom_range(4, 0) == 0) begin
            radix = iconv_pkg::RADIX_BITS'($urandom_range(127, 0));
         end else begin
            radix = iconv_pkg::RADIX_BITS'($urandom_range(36, 0));
            if ($urandom_range(1, 0)) radix = -radix;
         end
         width = ($urandom_range(2, 0) == 0) ? '0
                 : iconv_pkg::WIDTH_BITS'($urandom_range(63, 0));
         send_number(value, radix, width, "");
      end
      req_tvalid <= 1'b0;

      while (pending_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // receiver: random hold-off per beat, one long hold-off on request
   initial begin : receiver
      int unsigned stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = LONG_HOLD;
         end else begin
            stall = rsp_quiet ? 0 : $urandom_range(MAX_IDLE, 0);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // compare each character beat against the oldest queued one
   always @(posedge clock) begin : check_chars
      ascii_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            report_fault($sformatf("unexpected character beat: %02h last %0b",
                                   rsp_tdata, rsp_tlast));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata !== {1'b0, want.code} || rsp_tlast !== want.last)
               report_fault($sformatf(
                  "character mismatch: expected %02h last %0b, got %02h last %0b",
                  {1'b0, want.code}, want.last, rsp_tdata, rsp_tlast));
         end
      end
   end

   // hang guard
   initial begin : watchdog
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
